// ===== rtl/core/sorted_wakeup_queue_defines.svh =====
// Assertion macros shared by the sorted wake-up queue RTL.
// Expects signals named aclk and aresetn in the including module.
`ifndef SORTED_WAKEUP_QUEUE_DEFINES_SVH
`define SORTED_WAKEUP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SWQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define SWQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/swq_pkg.sv =====
// Package for the sorted wake-up queue: result kinds, operation codes,
// sequencer states and shared structs. No dependencies.
`timescale 1ns / 1ps

package swq_pkg;

    // Operation carried by a request
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Maximum entries woken by one tick request
    localparam int MAX_POPS = 16;
    localparam int POP_W    = $clog2(MAX_POPS + 1);

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_WOKEN    = 2'd2,
        KIND_NONE     = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_RESP,
        ST_TK_CMP,
        ST_TK_LAST
    } state_t;

    // One stored queue entry
    typedef struct packed {
        logic [63:0] wake_time;
        logic [7:0]  task_id;
    } swq_entry_t;

    // Result offered by the sequencer to the output register
    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] task_id;
        logic       last;
    } swq_res_t;

endpackage

// ===== rtl/core/sorted_wakeup_queue.sv =====
// Sorted wake-up queue: insert walks from the tail one entry per cycle, result
// registered in the output register; tick pops one entry per cycle while the output register is free.
// A request is taken only when the sequencer is idle; the shared compare sets the pace.
// Reset (aresetn low, synchronous) empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module sorted_wakeup_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [135:0] s_tdata,   // task_id[7:0], wake_time[71:8], now_ticks[135:72]
    input  logic [0:0]   s_tuser,   // operation[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // woken_task[7:0]
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast
);
    import swq_pkg::*;

    swq_res_t   res;
    logic       out_free;
    logic       m_valid_reg;
    kind_t      m_kind_reg;
    logic [7:0] m_task_reg;
    logic       m_last_reg;

    swq_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser[0]),
        .in_task  (s_tdata[7:0]),
        .in_wake  (s_tdata[71:8]),
        .in_now   (s_tdata[135:72]),
        .out_free (out_free),
        .res      (res)
    );

    // Output register: loads whenever it is empty or being drained
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            m_kind_reg <= res.kind;
            m_task_reg <= res.task_id;
            m_last_reg <= res.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_task_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== rtl/core/swq_store.sv =====
// Entry memory of the sorted wake-up queue: one write port, one read port
// with registered read data. Depends on swq_pkg.
`timescale 1ns / 1ps

module swq_store #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                             aclk,
    input  logic                                             wr_en,
    input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] wr_addr,
    input  swq_pkg::swq_entry_t                              wr_data,
    input  logic                                             rd_en,
    input  logic [((QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1)-1:0] rd_addr,
    output swq_pkg::swq_entry_t                              rd_data
);
    import swq_pkg::*;

    swq_entry_t mem [QUEUE_DEPTH];
    swq_entry_t rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/swq_ctrl.sv =====
// Sequencer of the sorted wake-up queue: ring pointers, one shared 64-bit
// compare, insertion walk and expiry pops. Depends on swq_pkg, swq_store and sorted_wakeup_queue_defines.svh.
`timescale 1ns / 1ps
`include "sorted_wakeup_queue_defines.svh"

module swq_ctrl #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_op,
    input  logic [7:0]          in_task,
    input  logic [63:0]         in_wake,
    input  logic [63:0]         in_now,
    input  logic                out_free,
    output swq_pkg::swq_res_t   res
);
    import swq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);
    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    // Logical queue position to ring slot
    function automatic logic [IDX_W-1:0] phys_addr(input logic [IDX_W-1:0] base,
                                                   input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [POP_W-1:0] pops_reg, pops_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_task_reg, pend_task_next;
    kind_t            kind_reg, kind_next;
    logic [7:0]       task_reg, task_next;
    logic [63:0]      wake_reg, wake_next;
    logic [63:0]      now_reg, now_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    swq_entry_t       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    swq_entry_t       rd_data;

    logic [63:0]      cmp_b;
    logic             cmp_le;
    logic [IDX_W-1:0] head_inc;

    swq_store #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared compare: stored wake time against new wake time or current tick
    assign cmp_b    = (state_reg == ST_TK_CMP) ? now_reg : wake_reg;
    assign cmp_le   = (rd_data.wake_time <= cmp_b);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            count_reg      <= '0;
            pops_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            pops_reg       <= pops_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        pend_task_reg <= pend_task_next;
        kind_reg      <= kind_next;
        task_reg      <= task_next;
        wake_reg      <= wake_next;
        now_reg       <= now_next;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        pops_next       = pops_reg;
        pend_valid_next = pend_valid_reg;
        pend_task_next  = pend_task_reg;
        kind_next       = kind_reg;
        task_next       = task_reg;
        wake_next       = wake_reg;
        now_next        = now_reg;
        in_ready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = phys_addr(head_reg, pos_reg);
        wr_data.wake_time = wake_reg;
        wr_data.task_id   = task_reg;
        rd_en           = 1'b0;
        rd_addr         = head_reg;
        res             = '0;

        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    task_next       = in_task;
                    wake_next       = in_wake;
                    now_next        = in_now;
                    pops_next       = '0;
                    pend_valid_next = 1'b0;
                    if (in_op == OP_INSERT) begin
                        if (count_reg == DEPTH_C) begin
                            kind_next  = KIND_FULL;
                            state_next = ST_RESP;
                        end else if (count_reg == '0) begin
                            // empty queue: new entry goes straight to the head
                            wr_en             = 1'b1;
                            wr_addr           = head_reg;
                            wr_data.wake_time = in_wake;
                            wr_data.task_id   = in_task;
                            count_next        = count_reg + CNT_W'(1);
                            kind_next         = KIND_ACCEPTED;
                            state_next        = ST_RESP;
                        end else begin
                            // hole at the tail, walk backwards from the last entry
                            pos_next   = count_reg[IDX_W-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = phys_addr(head_reg,
                                                   count_reg[IDX_W-1:0] - IDX_W'(1));
                            state_next = ST_INS_CMP;
                        end
                    end else begin
                        if (count_reg == '0) begin
                            kind_next  = KIND_NONE;
                            state_next = ST_RESP;
                        end else begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = ST_TK_CMP;
                        end
                    end
                end
            end

            ST_INS_CMP: begin
                wr_en = 1'b1;
                if (cmp_le) begin
                    // entry before the hole is not later: new entry fills the hole
                    count_next = count_reg + CNT_W'(1);
                    kind_next  = KIND_ACCEPTED;
                    state_next = ST_RESP;
                end else begin
                    // move the later entry up into the hole
                    wr_data  = rd_data;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1)) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = phys_addr(head_reg, pos_reg - IDX_W'(2));
                    end
                end
            end

            ST_INS_PUT: begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                kind_next  = KIND_ACCEPTED;
                state_next = ST_RESP;
            end

            ST_RESP: begin
                res.valid = 1'b1;
                res.kind  = kind_reg;
                res.last  = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            ST_TK_CMP: begin
                if (out_free) begin
                    if (cmp_le) begin
                        // head expired: pop it, release the previous pop as non-last
                        head_next  = head_inc;
                        count_next = count_reg - CNT_W'(1);
                        pops_next  = pops_reg + POP_W'(1);
                        if (pend_valid_reg) begin
                            res.valid   = 1'b1;
                            res.kind    = KIND_WOKEN;
                            res.task_id = pend_task_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_task_next  = rd_data.task_id;
                        if (count_reg != CNT_W'(1) && pops_reg != POP_W'(MAX_POPS - 1)) begin
                            rd_en   = 1'b1;
                            rd_addr = head_inc;
                        end else begin
                            state_next = ST_TK_LAST;
                        end
                    end else begin
                        // head not due: close the run
                        res.valid = 1'b1;
                        res.last  = 1'b1;
                        if (pend_valid_reg) begin
                            res.kind    = KIND_WOKEN;
                            res.task_id = pend_task_reg;
                        end else begin
                            res.kind = KIND_NONE;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_TK_LAST: begin
                res.valid   = 1'b1;
                res.kind    = KIND_WOKEN;
                res.task_id = pend_task_reg;
                res.last    = 1'b1;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SWQ_ASSERT_IMP(a_write_only_insert, wr_en, (state_reg == ST_IDLE || state_reg == ST_INS_CMP || state_reg == ST_INS_PUT), "store written outside an insert")
    `SWQ_ASSERT_IMP(a_tick_cmp_bounds, state_reg == ST_TK_CMP, (pops_reg < POP_W'(MAX_POPS) && count_reg != '0), "tick compare with empty queue or pop limit reached")
    `SWQ_ASSERT_NEXT(a_woken_not_last, (res.valid && res.kind == KIND_WOKEN && !res.last), (state_reg == ST_TK_CMP || state_reg == ST_TK_LAST), "non-last wake not followed by another wake")
    `SWQ_ASSERT_NEXT(a_full_keeps_count, (in_valid && in_ready && in_op == OP_INSERT && count_reg == DEPTH_C), $stable(count_reg), "insert into full queue changed the count")

endmodule
